// ===== rtl/core/lwa_pkg.sv =====
// ----------------------------------------------------------------------------
// lwa_pkg
// Shared types, codes and defaults of the lattice walk aggregation step.
// ----------------------------------------------------------------------------
package lwa_pkg;

	localparam int MAX_PARTICLES_DEF = 256;
	localparam int MAX_ROWS_DEF      = 64;
	localparam int MAX_COLS_DEF      = 64;

	localparam int ID_W  = 8;
	localparam int POS_W = 6;
	localparam int DIR_W = 4;
	localparam int CFG_W = 7;

	localparam logic [CFG_W-1:0] GRID_DIM_RESET = 7'd64;
	localparam int               GRID_DIM_MAX   = 64;

	localparam logic CFG_GRID_WIDTH  = 1'b0;
	localparam logic CFG_GRID_HEIGHT = 1'b1;

	localparam logic ACT_PLACE = 1'b0;
	localparam logic ACT_STEP  = 1'b1;

	localparam logic MOVING     = 1'b1;
	localparam logic STATIONARY = 1'b0;

	typedef enum logic [2:0] {
		OUT_MOVED      = 3'd0,
		OUT_STUCK      = 3'd1,
		OUT_REJECTED   = 3'd2,
		OUT_STATIONARY = 3'd3,
		OUT_PLACED     = 3'd4,
		OUT_REFUSED    = 3'd5
	} outcome_t;

	typedef struct packed {
		logic             action;
		logic [ID_W-1:0]  particle_id;
		logic [POS_W-1:0] start_row;
		logic [POS_W-1:0] start_col;
		logic             start_moving;
		logic [DIR_W-1:0] direction;
	} in_item_t;

	typedef struct packed {
		logic [ID_W-1:0]  particle_id_out;
		logic [POS_W-1:0] row_out;
		logic [POS_W-1:0] col_out;
		logic             moving_out;
		outcome_t         outcome;
		logic [ID_W-1:0]  hit_id;
	} out_item_t;

	// offset codes: 0 means -1, 1 means 0, 2 means +1
	typedef struct packed {
		logic       bad;
		logic [1:0] drow;
		logic [1:0] dcol;
	} dir_t;

	function automatic dir_t dir_decode(input logic [DIR_W-1:0] code);
		dir_t d;
		d = '{bad: 1'b1, drow: 2'd1, dcol: 2'd1};
		case (code)
			4'd0: d = '{bad: 1'b0, drow: 2'd0, dcol: 2'd0};
			4'd1: d = '{bad: 1'b0, drow: 2'd0, dcol: 2'd1};
			4'd2: d = '{bad: 1'b0, drow: 2'd0, dcol: 2'd2};
			4'd3: d = '{bad: 1'b0, drow: 2'd1, dcol: 2'd0};
			4'd5: d = '{bad: 1'b0, drow: 2'd1, dcol: 2'd2};
			4'd6: d = '{bad: 1'b0, drow: 2'd2, dcol: 2'd0};
			4'd7: d = '{bad: 1'b0, drow: 2'd2, dcol: 2'd1};
			4'd8: d = '{bad: 1'b0, drow: 2'd2, dcol: 2'd2};
			default: d = '{bad: 1'b1, drow: 2'd1, dcol: 2'd1};
		endcase
		return d;
	endfunction

endpackage

// ===== rtl/core/lwa_stream_if.sv =====
// ----------------------------------------------------------------------------
// lwa_stream_if
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface lwa_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/lattice_walk_aggregation_step.sv =====
// ----------------------------------------------------------------------------
// lattice_walk_aggregation_step
// Particle table and cell map for a lattice walk with aggregation.
//
// channel   dir  payload      transaction
// items     in   in_item_t    one place or step request
// results   out  out_item_t   one result per request
// cfg_*     in   7-bit data   register write, no handshake
//
// Clearing pass after reset over all MAX_ROWS*MAX_COLS cells, items held
// off, config writes taken.
// Per item, accept to next accept: refused, stationary and rejected pass
// S_READ and S_EMIT only; placed, moved and stuck add dependent read and
// write-back states on the cell map and particle table between them.
// A result waits in the output register; the next item completes its
// memory work and then holds until that register is free.
// ----------------------------------------------------------------------------
module lattice_walk_aggregation_step #(
	parameter int MAX_PARTICLES = lwa_pkg::MAX_PARTICLES_DEF,
	parameter int MAX_ROWS      = lwa_pkg::MAX_ROWS_DEF,
	parameter int MAX_COLS      = lwa_pkg::MAX_COLS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	lwa_stream_if.sink              items,
	lwa_stream_if.source            results,
	input  logic                    cfg_wen,
	input  logic                    cfg_idx,
	input  logic [lwa_pkg::CFG_W-1:0] cfg_wdata
);
	import lwa_pkg::*;

	localparam int PID_W    = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
	localparam int CM_DEPTH = MAX_ROWS * MAX_COLS;
	localparam int CA_W     = $clog2(CM_DEPTH);
	localparam int LIM_W    = (MAX_COLS < GRID_DIM_MAX) ? MAX_COLS : GRID_DIM_MAX;
	localparam int LIM_H    = (MAX_ROWS < GRID_DIM_MAX) ? MAX_ROWS : GRID_DIM_MAX;
	localparam int ID_SPAN  = 1 << ID_W;

	typedef struct packed {
		logic             valid;
		logic [PID_W-1:0] id;
	} cell_t;

	typedef struct packed {
		logic [POS_W-1:0] row;
		logic [POS_W-1:0] col;
		logic             moving;
	} entry_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_READ,
		S_PLACE_CLR,
		S_PLACE_WR,
		S_STEP_HIT,
		S_STUCK_WR,
		S_STEP_MV,
		S_EMIT
	} state_t;

	function automatic logic [CA_W-1:0] cell_addr(input logic [POS_W-1:0] r,
	                                              input logic [POS_W-1:0] c);
		return CA_W'(CA_W'(r) * CA_W'(MAX_COLS)) + CA_W'(c);
	endfunction

	// particle id reduced modulo the table depth
	logic [PID_W-1:0] pid_lut [ID_SPAN];
	for (genvar g = 0; g < ID_SPAN; g++) begin : g_pid
		assign pid_lut[g] = PID_W'(g % MAX_PARTICLES);
	end

	state_t           state_q;
	logic [CA_W-1:0]  clr_q;
	logic [CFG_W-1:0] gw_q, gh_q;
	logic [CFG_W-1:0] w_eff, h_eff;

	logic             act_q;
	logic [ID_W-1:0]  pid_q;
	logic [PID_W-1:0] p_q;
	logic [POS_W-1:0] srow_q, scol_q;
	logic             smov_q;
	logic [DIR_W-1:0] dir_q;
	logic [POS_W-1:0] erow_q, ecol_q;
	logic [POS_W-1:0] nrow_q, ncol_q;
	logic [CA_W-1:0]  tgt_addr_q, old_addr_q;
	logic             old_ok_q;
	logic [PID_W-1:0] hit_q;
	out_item_t        res_q;
	out_item_t        out_q;
	logic             out_valid_q;

	// memories
	cell_t            cm_mem [CM_DEPTH];
	entry_t           pt_mem [MAX_PARTICLES];
	cell_t            cm_rdata;
	entry_t           pt_rdata;
	logic             cm_we, cm_re, pt_we, pt_re;
	logic [CA_W-1:0]  cm_waddr, cm_raddr;
	cell_t            cm_wdata;
	logic [PID_W-1:0] pt_waddr, pt_raddr;
	entry_t           pt_wdata;

	always_ff @(posedge clk) begin
		if (cm_we) begin
			cm_mem[cm_waddr] <= cm_wdata;
		end
		if (cm_re) begin
			cm_rdata <= cm_mem[cm_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (pt_we) begin
			pt_mem[pt_waddr] <= pt_wdata;
		end
		if (pt_re) begin
			pt_rdata <= pt_mem[pt_raddr];
		end
	end

	always_comb begin
		w_eff = gw_q;
		if (gw_q == '0) begin
			w_eff = CFG_W'(1);
		end else if (gw_q > CFG_W'(LIM_W)) begin
			w_eff = CFG_W'(LIM_W);
		end
		h_eff = gh_q;
		if (gh_q == '0) begin
			h_eff = CFG_W'(1);
		end else if (gh_q > CFG_W'(LIM_H)) begin
			h_eff = CFG_W'(LIM_H);
		end
	end

	// step evaluation on the freshly read entry
	dir_t             dd;
	logic [CFG_W-1:0] nrow7, ncol7;
	logic             step_rej;
	logic             place_ref;
	logic             old_ok;
	logic             accept;

	always_comb begin
		dd    = dir_decode(dir_q);
		nrow7 = {1'b0, pt_rdata.row} + {5'b0, dd.drow} - CFG_W'(1);
		ncol7 = {1'b0, pt_rdata.col} + {5'b0, dd.dcol} - CFG_W'(1);
		step_rej = dd.bad
			|| (dd.drow == 2'd0 && pt_rdata.row == '0)
			|| (dd.dcol == 2'd0 && pt_rdata.col == '0)
			|| (nrow7 >= h_eff) || (ncol7 >= w_eff);
		place_ref = ({1'b0, srow_q} >= h_eff) || ({1'b0, scol_q} >= w_eff)
			|| (cm_rdata.valid && cm_rdata.id != p_q);
		old_ok = (32'(pt_rdata.row) < MAX_ROWS) && (32'(pt_rdata.col) < MAX_COLS);
		accept = items.valid && (state_q == S_IDLE);
	end

	always_comb begin
		cm_we    = 1'b0;
		cm_waddr = tgt_addr_q;
		cm_wdata = '0;
		cm_re    = 1'b0;
		cm_raddr = cell_addr(items.data.start_row, items.data.start_col);
		pt_we    = 1'b0;
		pt_waddr = p_q;
		pt_wdata = '{row: erow_q, col: ecol_q, moving: STATIONARY};
		pt_re    = 1'b0;
		pt_raddr = pid_lut[items.data.particle_id];
		case (state_q)
			S_CLEAR: begin
				cm_we    = 1'b1;
				cm_waddr = clr_q;
			end
			S_IDLE: begin
				pt_re = accept;
				cm_re = accept;
			end
			S_READ: begin
				if (act_q == ACT_PLACE) begin
					cm_re    = !place_ref;
					cm_raddr = cell_addr(pt_rdata.row, pt_rdata.col);
				end else begin
					cm_re    = pt_rdata.moving && !step_rej;
					cm_raddr = cell_addr(POS_W'(nrow7), POS_W'(ncol7));
				end
			end
			S_PLACE_CLR: begin
				cm_we    = old_ok_q && cm_rdata.valid && cm_rdata.id == p_q;
				cm_waddr = old_addr_q;
				pt_we    = 1'b1;
				pt_wdata = '{row: srow_q, col: scol_q, moving: smov_q};
			end
			S_PLACE_WR, S_STEP_MV: begin
				cm_we    = 1'b1;
				cm_wdata = '{valid: 1'b1, id: p_q};
			end
			S_STEP_HIT: begin
				pt_we = 1'b1;
				if (cm_rdata.valid) begin
					pt_re    = 1'b1;
					pt_raddr = cm_rdata.id;
				end else begin
					cm_we    = 1'b1;
					cm_waddr = old_addr_q;
					pt_wdata = '{row: nrow_q, col: ncol_q, moving: MOVING};
				end
			end
			S_STUCK_WR: begin
				pt_we    = 1'b1;
				pt_waddr = hit_q;
				pt_wdata = '{row: pt_rdata.row, col: pt_rdata.col, moving: STATIONARY};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			gw_q        <= GRID_DIM_RESET;
			gh_q        <= GRID_DIM_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wen) begin
				case (cfg_idx)
					CFG_GRID_WIDTH:  gw_q <= cfg_wdata;
					CFG_GRID_HEIGHT: gh_q <= cfg_wdata;
					default: begin
					end
				endcase
			end
			if (out_valid_q && results.ready && state_q != S_EMIT) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + CA_W'(1);
					if (clr_q == CA_W'(CM_DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						act_q      <= items.data.action;
						pid_q      <= items.data.particle_id;
						p_q        <= pid_lut[items.data.particle_id];
						srow_q     <= items.data.start_row;
						scol_q     <= items.data.start_col;
						smov_q     <= items.data.start_moving;
						dir_q      <= items.data.direction;
						tgt_addr_q <= cell_addr(items.data.start_row, items.data.start_col);
						state_q    <= S_READ;
					end
				end
				S_READ: begin
					erow_q     <= pt_rdata.row;
					ecol_q     <= pt_rdata.col;
					nrow_q     <= POS_W'(nrow7);
					ncol_q     <= POS_W'(ncol7);
					old_addr_q <= cell_addr(pt_rdata.row, pt_rdata.col);
					old_ok_q   <= old_ok;
					res_q.particle_id_out <= pid_q;
					res_q.hit_id          <= '0;
					if (act_q == ACT_PLACE) begin
						res_q.row_out <= srow_q;
						res_q.col_out <= scol_q;
						if (place_ref) begin
							res_q.moving_out <= STATIONARY;
							res_q.outcome    <= OUT_REFUSED;
							state_q          <= S_EMIT;
						end else begin
							res_q.moving_out <= smov_q;
							res_q.outcome    <= OUT_PLACED;
							state_q          <= S_PLACE_CLR;
						end
					end else if (!pt_rdata.moving) begin
						res_q.row_out    <= pt_rdata.row;
						res_q.col_out    <= pt_rdata.col;
						res_q.moving_out <= STATIONARY;
						res_q.outcome    <= OUT_STATIONARY;
						state_q          <= S_EMIT;
					end else if (step_rej) begin
						res_q.row_out    <= pt_rdata.row;
						res_q.col_out    <= pt_rdata.col;
						res_q.moving_out <= MOVING;
						res_q.outcome    <= OUT_REJECTED;
						state_q          <= S_EMIT;
					end else begin
						tgt_addr_q <= cell_addr(POS_W'(nrow7), POS_W'(ncol7));
						state_q    <= S_STEP_HIT;
					end
				end
				S_PLACE_CLR: state_q <= S_PLACE_WR;
				S_PLACE_WR:  state_q <= S_EMIT;
				S_STEP_HIT: begin
					if (cm_rdata.valid) begin
						hit_q            <= cm_rdata.id;
						res_q.row_out    <= erow_q;
						res_q.col_out    <= ecol_q;
						res_q.moving_out <= STATIONARY;
						res_q.outcome    <= OUT_STUCK;
						res_q.hit_id     <= ID_W'(cm_rdata.id);
						state_q          <= S_STUCK_WR;
					end else begin
						res_q.row_out    <= nrow_q;
						res_q.col_out    <= ncol_q;
						res_q.moving_out <= MOVING;
						res_q.outcome    <= OUT_MOVED;
						state_q          <= S_STEP_MV;
					end
				end
				S_STUCK_WR: state_q <= S_EMIT;
				S_STEP_MV:  state_q <= S_EMIT;
				S_EMIT: begin
					if (!out_valid_q || results.ready) begin
						out_q       <= res_q;
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign items.ready   = (state_q == S_IDLE);
	assign results.valid = out_valid_q;
	assign results.data  = out_q;

endmodule

// ===== verif/aggregation_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aggregation_checker
// Watches the item, result and register write ports of the lattice walk
// block. Keeps its own copy of the particle table, the cell map and the
// grid size, works out the result of every accepted item and compares each
// result transaction, field by field, with the oldest outstanding one.
// ----------------------------------------------------------------------------
module aggregation_checker (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  item_valid,
	input  logic                                  item_ready,
	input  lwa_pkg::in_item_t                     item_data,
	input  logic                                  result_valid,
	input  logic                                  result_ready,
	input  lwa_pkg::out_item_t                    result_data,
	input  logic                                  cfg_wen,
	input  logic                                  cfg_idx,
	input  logic [lwa_pkg::CFG_W-1:0]             cfg_wdata,
	output int                                    fail_count,
	output int                                    outstanding,
	output int                                    compared,
	output logic [lwa_pkg::MAX_PARTICLES_DEF-1:0] placed_mask
);
	import lwa_pkg::*;

	localparam int CELLS = MAX_ROWS_DEF * MAX_COLS_DEF;
	localparam int OFFSET_BASE = 3;
	localparam logic [DIR_W-1:0] DIR_STAY = 4'd4;
	localparam logic [DIR_W-1:0] DIR_LAST = 4'd8;
	localparam int REPORT_LIMIT = 40;

	logic                         cell_held   [CELLS];
	logic [ID_W-1:0]              cell_owner  [CELLS];
	logic [POS_W-1:0]             part_row    [MAX_PARTICLES_DEF];
	logic [POS_W-1:0]             part_col    [MAX_PARTICLES_DEF];
	logic                         part_moving [MAX_PARTICLES_DEF];
	logic [CFG_W-1:0]             width_reg;
	logic [CFG_W-1:0]             height_reg;
	logic [MAX_PARTICLES_DEF-1:0] placed;
	out_item_t                    expected_results [$];
	out_item_t                    want;
	int                           errors;
	int                           checks;

	function automatic int dim_in_use(logic [CFG_W-1:0] v, int maxdim);
		int lim;
		lim = (maxdim < GRID_DIM_MAX) ? maxdim : GRID_DIM_MAX;
		if (v == 0)
			return 1;
		if (int'(v) > lim)
			return lim;
		return int'(v);
	endfunction

	function automatic int cell_at(int row, int col);
		return (row % MAX_ROWS_DEF) * MAX_COLS_DEF + (col % MAX_COLS_DEF);
	endfunction

	function automatic out_item_t apply_item(in_item_t it);
		out_item_t r;
		int w, h, p, tgt, old, drow, dcol, nrow, ncol, q;
		w = dim_in_use(width_reg, MAX_COLS_DEF);
		h = dim_in_use(height_reg, MAX_ROWS_DEF);
		p = int'(it.particle_id) % MAX_PARTICLES_DEF;
		r.particle_id_out = it.particle_id;
		r.hit_id = '0;

		if (it.action == ACT_PLACE) begin
			tgt = cell_at(it.start_row, it.start_col);
			r.row_out = it.start_row;
			r.col_out = it.start_col;
			if (int'(it.start_row) >= h || int'(it.start_col) >= w ||
			    (cell_held[tgt] && int'(cell_owner[tgt]) != p)) begin
				r.moving_out = STATIONARY;
				r.outcome = OUT_REFUSED;
				return r;
			end
			old = cell_at(part_row[p], part_col[p]);
			if (cell_held[old] && int'(cell_owner[old]) == p)
				cell_held[old] = 1'b0;
			part_row[p] = it.start_row;
			part_col[p] = it.start_col;
			part_moving[p] = it.start_moving;
			cell_held[tgt] = 1'b1;
			cell_owner[tgt] = ID_W'(p);
			placed[p] = 1'b1;
			r.moving_out = it.start_moving;
			r.outcome = OUT_PLACED;
			return r;
		end

		r.row_out = part_row[p];
		r.col_out = part_col[p];
		if (part_moving[p] == STATIONARY) begin
			r.moving_out = STATIONARY;
			r.outcome = OUT_STATIONARY;
			return r;
		end

		r.moving_out = MOVING;
		r.outcome = OUT_REJECTED;
		drow = int'(it.direction) / OFFSET_BASE;
		dcol = int'(it.direction) % OFFSET_BASE;
		if (it.direction > DIR_LAST || it.direction == DIR_STAY ||
		    (drow == 0 && part_row[p] == 0) || (dcol == 0 && part_col[p] == 0))
			return r;
		nrow = int'(part_row[p]) + drow - 1;
		ncol = int'(part_col[p]) + dcol - 1;
		if (nrow >= h || ncol >= w)
			return r;

		tgt = cell_at(nrow, ncol);
		if (cell_held[tgt]) begin
			q = int'(cell_owner[tgt]) % MAX_PARTICLES_DEF;
			part_moving[q] = STATIONARY;
			part_moving[p] = STATIONARY;
			r.moving_out = STATIONARY;
			r.outcome = OUT_STUCK;
			r.hit_id = ID_W'(q);
			return r;
		end

		old = cell_at(part_row[p], part_col[p]);
		if (cell_held[old] && int'(cell_owner[old]) == p)
			cell_held[old] = 1'b0;
		cell_held[tgt] = 1'b1;
		cell_owner[tgt] = ID_W'(p);
		part_row[p] = POS_W'(nrow);
		part_col[p] = POS_W'(ncol);
		r.row_out = POS_W'(nrow);
		r.col_out = POS_W'(ncol);
		r.outcome = OUT_MOVED;
		return r;
	endfunction

	task automatic check_field(string name, int id, int exp_val, int got_val);
		if (exp_val != got_val) begin
			errors++;
			if (errors <= REPORT_LIMIT)
				$display("%0t: particle %0d %s expected %0d actual %0d",
				         $time, id, name, exp_val, got_val);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CELLS; i++) begin
				cell_held[i] = 1'b0;
				cell_owner[i] = '0;
			end
			for (int i = 0; i < MAX_PARTICLES_DEF; i++) begin
				part_row[i] = '0;
				part_col[i] = '0;
				part_moving[i] = STATIONARY;
			end
			width_reg = GRID_DIM_RESET;
			height_reg = GRID_DIM_RESET;
			placed = '0;
			expected_results.delete();
			errors = 0;
			checks = 0;
			fail_count <= 0;
			outstanding <= 0;
			compared <= 0;
			placed_mask <= '0;
		end else begin
			if (result_valid && result_ready) begin
				if (expected_results.size() == 0) begin
					errors++;
					if (errors <= REPORT_LIMIT)
						$display("%0t: result for particle %0d with nothing expected",
						         $time, result_data.particle_id_out);
				end else begin
					want = expected_results.pop_front();
					checks++;
					check_field("particle_id_out", want.particle_id_out,
					            want.particle_id_out, result_data.particle_id_out);
					check_field("row_out", want.particle_id_out,
					            want.row_out, result_data.row_out);
					check_field("col_out", want.particle_id_out,
					            want.col_out, result_data.col_out);
					check_field("moving_out", want.particle_id_out,
					            want.moving_out, result_data.moving_out);
					check_field("outcome", want.particle_id_out,
					            want.outcome, result_data.outcome);
					check_field("hit_id", want.particle_id_out,
					            want.hit_id, result_data.hit_id);
				end
			end
			if (cfg_wen) begin
				if (cfg_idx == CFG_GRID_WIDTH)
					width_reg = cfg_wdata;
				else
					height_reg = cfg_wdata;
			end
			if (item_valid && item_ready)
				expected_results.push_back(apply_item(item_data));
			fail_count <= errors;
			outstanding <= expected_results.size();
			compared <= checks;
			placed_mask <= placed;
		end
	end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the lattice walk aggregation step. A directed
// pass covers placing, refusal, rejection, collision and plain moves; then
// random phases with different grid sizes drive crowded particle walks in
// small groups or all ids, random gaps on both sides, one long output hold.
// ----------------------------------------------------------------------------
module testbench;
	import lwa_pkg::*;

	localparam int HALF_PERIOD  = 10;
	localparam int RESET_CYCLES = 7;
	localparam int RANDOM_ITEMS = 1200;
	localparam int PHASES       = 8;
	localparam int MAX_GAP      = 14;
	localparam int LONG_HOLD    = 400;
	localparam int HOLD_AT      = 500;
	localparam int SETTLE       = 12;
	localparam int RUN_LIMIT_NS = 5_000_000;

	localparam logic [DIR_W-1:0] DIR_UP_LEFT    = 4'd0;
	localparam logic [DIR_W-1:0] DIR_UP         = 4'd1;
	localparam logic [DIR_W-1:0] DIR_UP_RIGHT   = 4'd2;
	localparam logic [DIR_W-1:0] DIR_LEFT       = 4'd3;
	localparam logic [DIR_W-1:0] DIR_STAY       = 4'd4;
	localparam logic [DIR_W-1:0] DIR_RIGHT      = 4'd5;
	localparam logic [DIR_W-1:0] DIR_DOWN_LEFT  = 4'd6;
	localparam logic [DIR_W-1:0] DIR_DOWN       = 4'd7;
	localparam logic [DIR_W-1:0] DIR_DOWN_RIGHT = 4'd8;
	localparam logic [DIR_W-1:0] DIR_LAST       = 4'd8;
	localparam logic [DIR_W-1:0] DIR_TOP        = 4'd15;

	logic                         clk       = 1'b0;
	logic                         arst_n    = 1'b0;
	logic                         cfg_wen   = 1'b0;
	logic                         cfg_idx   = CFG_GRID_WIDTH;
	logic [CFG_W-1:0]             cfg_wdata = '0;
	int                           fail_count;
	int                           outstanding;
	int                           compared;
	logic [MAX_PARTICLES_DEF-1:0] placed_mask;

	int sent;
	int settings;
	int results_seen;
	int rows_in_use;
	int cols_in_use;
	int pool_base;
	int pool_size;
	bit send_calm;
	bit recv_calm;

	lwa_stream_if #(.payload_t(in_item_t))  items_if ();
	lwa_stream_if #(.payload_t(out_item_t)) results_if ();

	lattice_walk_aggregation_step DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.items     (items_if),
		.results   (results_if),
		.cfg_wen   (cfg_wen),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	aggregation_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (items_if.valid),
		.item_ready   (items_if.ready),
		.item_data    (items_if.data),
		.result_valid (results_if.valid),
		.result_ready (results_if.ready),
		.result_data  (results_if.data),
		.cfg_wen      (cfg_wen),
		.cfg_idx      (cfg_idx),
		.cfg_wdata    (cfg_wdata),
		.fail_count   (fail_count),
		.outstanding  (outstanding),
		.compared     (compared),
		.placed_mask  (placed_mask)
	);

	always #(HALF_PERIOD) clk = ~clk;

	function automatic int dim_span(logic [CFG_W-1:0] v);
		if (v == 0)
			return 1;
		if (int'(v) > GRID_DIM_MAX)
			return GRID_DIM_MAX;
		return int'(v);
	endfunction

	function automatic in_item_t place_item(logic [ID_W-1:0] id, logic [POS_W-1:0] row,
	                                        logic [POS_W-1:0] col, logic moving);
		in_item_t it;
		it.action = ACT_PLACE;
		it.particle_id = id;
		it.start_row = row;
		it.start_col = col;
		it.start_moving = moving;
		it.direction = DIR_W'($urandom_range(0, DIR_TOP));
		return it;
	endfunction

	function automatic in_item_t step_item(logic [ID_W-1:0] id, logic [DIR_W-1:0] dir);
		in_item_t it;
		it.action = ACT_STEP;
		it.particle_id = id;
		it.start_row = POS_W'($urandom);
		it.start_col = POS_W'($urandom);
		it.start_moving = 1'($urandom);
		it.direction = dir;
		return it;
	endfunction

	function automatic logic [ID_W-1:0] pool_id();
		return ID_W'(pool_base + $urandom_range(0, pool_size - 1));
	endfunction

	// mostly steps of particles already on the grid, places fill the pool
	function automatic in_item_t random_item();
		in_item_t it;
		logic [ID_W-1:0] id;
		bit found;
		found = 1'b0;
		id = pool_id();
		if ($urandom_range(0, 3) != 0) begin
			for (int k = 0; k < 16 && !found; k++) begin
				id = pool_id();
				found = placed_mask[id];
			end
		end
		if (found) begin
			if ($urandom_range(0, 9) == 0)
				it = step_item(id, DIR_W'($urandom_range(0, DIR_TOP)));
			else
				it = step_item(id, DIR_W'($urandom_range(0, DIR_LAST)));
		end else begin
			if ($urandom_range(0, 9) == 0)
				id = ID_W'($urandom);
			if ($urandom_range(0, 4) == 0)
				it = place_item(id, POS_W'($urandom), POS_W'($urandom),
				                1'($urandom_range(0, 4) != 0));
			else
				it = place_item(id, POS_W'($urandom_range(0, rows_in_use - 1)),
				                POS_W'($urandom_range(0, cols_in_use - 1)),
				                1'($urandom_range(0, 4) != 0));
		end
		return it;
	endfunction

	task automatic send(in_item_t it);
		int gap;
		if ($urandom_range(0, 39) == 0)
			send_calm = !send_calm;
		gap = send_calm ? 0 : $urandom_range(0, MAX_GAP);
		if (gap > 0) begin
			items_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		items_if.data <= it;
		items_if.valid <= 1'b1;
		do @(posedge clk); while (!items_if.ready);
		sent++;
	endtask

	task automatic drain();
		items_if.valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_grid(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h);
		@(posedge clk);
		cfg_wen <= 1'b1;
		cfg_idx <= CFG_GRID_WIDTH;
		cfg_wdata <= w;
		@(posedge clk);
		cfg_idx <= CFG_GRID_HEIGHT;
		cfg_wdata <= h;
		@(posedge clk);
		cfg_wen <= 1'b0;
		cols_in_use = dim_span(w);
		rows_in_use = dim_span(h);
		settings++;
	endtask

	initial begin
		int stall;
		results_if.ready <= 1'b0;
		results_seen = 0;
		recv_calm = 1'b0;
		wait (arst_n);
		forever begin
			if ($urandom_range(0, 39) == 0)
				recv_calm = !recv_calm;
			if (results_seen == HOLD_AT)
				stall = LONG_HOLD;
			else
				stall = recv_calm ? 0 : $urandom_range(0, MAX_GAP);
			if (stall > 0) begin
				results_if.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			results_if.ready <= 1'b1;
			do @(posedge clk); while (!results_if.valid);
			results_seen++;
		end
	end

	initial begin
		logic [CFG_W-1:0] w;
		logic [CFG_W-1:0] h;
		items_if.valid <= 1'b0;
		items_if.data <= '0;
		sent = 0;
		settings = 1;
		send_calm = 1'b0;
		rows_in_use = dim_span(GRID_DIM_RESET);
		cols_in_use = dim_span(GRID_DIM_RESET);
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// directed pass on the full grid left by reset
		send(place_item(8'd0, 6'd0, 6'd0, MOVING));
		send(place_item(8'd255, 6'd63, 6'd63, MOVING));
		send(step_item(8'd0, DIR_UP_LEFT));
		send(step_item(8'd0, DIR_STAY));
		send(step_item(8'd0, DIR_LAST + 4'd1));
		send(step_item(8'd0, DIR_TOP));
		send(step_item(8'd255, DIR_DOWN_RIGHT));
		send(step_item(8'd0, DIR_DOWN_RIGHT));
		send(place_item(8'd1, 6'd2, 6'd2, STATIONARY));
		send(step_item(8'd0, DIR_DOWN_RIGHT));
		send(step_item(8'd0, DIR_DOWN));
		send(step_item(8'd1, DIR_RIGHT));
		send(place_item(8'd2, 6'd2, 6'd2, MOVING));
		send(place_item(8'd1, 6'd2, 6'd2, MOVING));
		send(place_item(8'd1, 6'd5, 6'd5, MOVING));
		send(place_item(8'd2, 6'd2, 6'd2, MOVING));
		send(step_item(8'd2, DIR_UP));
		send(step_item(8'd2, DIR_LEFT));
		send(step_item(8'd255, DIR_UP_LEFT));
		send(step_item(8'd255, DIR_RIGHT));
		send(step_item(8'd255, DIR_UP_RIGHT));
		drain();

		// zero width counts as one column, oversized height as the full 64 rows
		write_grid(7'd0, 7'd127);
		send(place_item(8'd4, 6'd0, 6'd1, MOVING));
		send(place_item(8'd4, 6'd40, 6'd0, MOVING));
		send(step_item(8'd4, DIR_DOWN));
		send(step_item(8'd4, DIR_DOWN_RIGHT));
		send(step_item(8'd4, DIR_DOWN_LEFT));
		drain();

		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: begin w = 7'd1; h = 7'd1; end
				1: begin w = 7'd64; h = 7'd64; end
				2: begin w = 7'd127; h = 7'd0; end
				3: begin w = CFG_W'($urandom); h = CFG_W'($urandom); end
				default: begin
					w = CFG_W'($urandom_range(2, 10));
					h = CFG_W'($urandom_range(2, 10));
				end
			endcase
			write_grid(w, h);
			pool_base = $urandom_range(0, MAX_PARTICLES_DEF - 1);
			pool_size = (ph == 1) ? MAX_PARTICLES_DEF : $urandom_range(4, 24);
			for (int n = 0; n < RANDOM_ITEMS / PHASES; n++)
				send(random_item());
			drain();
		end

		repeat (SETTLE) @(posedge clk);
		$display("Run covered %0d transactions under %0d grid settings, %0d results compared,",
		         sent, settings, compared);
		$display("including one output hold of %0d cycles with the input backed up.", LONG_HOLD);
		if (fail_count == 0 && outstanding == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		#(RUN_LIMIT_NS);
		$display("Timeout with %0d results still outstanding", outstanding);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/lwa_pkg.sv
rtl/core/lwa_stream_if.sv
rtl/core/lattice_walk_aggregation_step.sv
verif/aggregation_checker.sv
verif/testbench.sv
